// ===== rtl/mva_pkg.sv =====
package mva_pkg;

   localparam int CHIP_TOTAL      = 2;
   localparam int VOICES_PER_CHIP = 6;
   localparam int NVOICES         = CHIP_TOTAL * VOICES_PER_CHIP;
   localparam int MAX_PATCHES     = 64;

   // field widths
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 7;
   localparam int VEL_W   = 7;
   localparam int SEL_W   = 7;
   localparam int EVENT_W = 2;
   localparam int VOICE_W = 4;
   localparam int PATCH_W = 6;
   localparam int COUNT_W = 7;
   localparam int FILL_W  = $clog2(NVOICES + 1);

   localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NVOICES - 1);

   // queue sizes
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_SELECT   = 2'd2,
      OP_ALL_OFF  = 2'd3
   } op_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_LOAD_PATCH = 2'd0,
      EV_KEY_ON     = 2'd1,
      EV_KEY_OFF    = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ON_LOAD,
      ST_ON_KEY,
      ST_OFF_SCAN,
      ST_ALL_SCAN
   } state_type;

   // classified command, front to back
   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [VEL_W-1:0]  vel;
      logic [SEL_W-1:0]  sel;
      logic              sel_ok;
   } cmd_type;

   // one result item
   typedef struct packed {
      event_type           ev;
      logic [VOICE_W-1:0]  voice;
      logic [PATCH_W-1:0]  patch;
      logic [KEY_W-1:0]    note;
      logic [VEL_W-1:0]    volume;
      logic                last;
   } rsp_type;

endpackage

// ===== rtl/mva_front.sv =====
module mva_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [mva_pkg::CMD_W-1:0]      cmd,
   input  logic [mva_pkg::KEY_W-1:0]      key,
   input  logic [mva_pkg::VEL_W-1:0]      velocity,
   input  logic [mva_pkg::SEL_W-1:0]      patch_select,
   input  logic [mva_pkg::COUNT_W-1:0]    patch_count,
   output logic                           cmd_empty,
   input  logic                           cmd_pop,
   output mva_pkg::cmd_type               cmd_head
);

   mva_pkg::cmd_type                    queue_ff [mva_pkg::CMDQ_DEPTH];
   logic [mva_pkg::CMDQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mva_pkg::CMDQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mva_pkg::CMDQ_CNT_W-1:0]      count_ff, count_in;
   mva_pkg::cmd_type                    classified;
   logic                                do_push;
   logic                                do_pop;

   // decode; patch request checked; user holds config static while busy, unenforced
   always_comb begin
      classified.key = key;
      classified.vel = velocity;
      classified.sel = patch_select;
      classified.sel_ok = (patch_select < patch_count) &&
                          ({1'b0, patch_select} < 8'(mva_pkg::MAX_PATCHES));
      // every 2-bit code is a defined command
      classified.op = mva_pkg::op_type'(cmd);
   end

   assign full      = (count_ff == mva_pkg::CMDQ_CNT_W'(mva_pkg::CMDQ_DEPTH));
   assign cmd_empty = (count_ff == '0);
   assign cmd_head  = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && !cmd_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== rtl/mva_back.sv =====
module mva_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  mva_pkg::cmd_type  cmd_head,
   input  logic              out_full,
   output logic              out_push,
   output mva_pkg::rsp_type  out_entry
);

   localparam int N = mva_pkg::NVOICES;

   mva_pkg::state_type              state_ff, state_in;
   logic                            busy_ff [N];
   logic                            busy_in [N];
   logic [mva_pkg::KEY_W-1:0]       note_ff [N];
   logic [mva_pkg::KEY_W-1:0]       note_in [N];
   logic [mva_pkg::PATCH_W-1:0]     patch_ff [N];
   logic [mva_pkg::PATCH_W-1:0]     patch_in [N];
   logic [mva_pkg::VOICE_W-1:0]     free_ff [N];
   logic [mva_pkg::VOICE_W-1:0]     free_in [N];
   logic [mva_pkg::VOICE_W-1:0]     head_ff, head_in;
   logic [mva_pkg::VOICE_W-1:0]     tail_ff, tail_in;
   logic [mva_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [mva_pkg::PATCH_W-1:0]     active_ff, active_in;
   logic [mva_pkg::VOICE_W-1:0]     voice_ff, voice_in;
   logic [mva_pkg::VOICE_W-1:0]     idx_ff, idx_in;
   logic [mva_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [mva_pkg::VEL_W-1:0]       vel_ff, vel_in;
   logic                            free_push;
   logic [mva_pkg::VOICE_W-1:0]     free_voice;

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      note_in    = note_ff;
      patch_in   = patch_ff;
      free_in    = free_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      active_in  = active_ff;
      voice_in   = voice_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      vel_in     = vel_ff;
      cmd_pop    = 1'b0;
      out_push   = 1'b0;
      out_entry  = '0;
      free_push  = 1'b0;
      free_voice = idx_ff;

      case (state_ff)
         mva_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               key_in  = cmd_head.key;
               vel_in  = cmd_head.vel;
               idx_in  = '0;
               case (cmd_head.op)
                  mva_pkg::OP_NOTE_ON: begin
                     // no free voice: the note is dropped
                     if (fill_ff != '0) begin
                        voice_in = free_ff[head_ff];
                        head_in  = (head_ff == mva_pkg::LAST_VOICE) ? '0 : head_ff + 1'b1;
                        fill_in  = fill_ff - 1'b1;
                        state_in = mva_pkg::ST_ON_LOAD;
                     end
                  end
                  mva_pkg::OP_NOTE_OFF: state_in = mva_pkg::ST_OFF_SCAN;
                  mva_pkg::OP_SELECT: begin
                     if (cmd_head.sel_ok) begin
                        active_in = cmd_head.sel[mva_pkg::PATCH_W-1:0];
                     end
                  end
                  default: state_in = mva_pkg::ST_ALL_SCAN;
               endcase
            end
         end

         mva_pkg::ST_ON_LOAD: begin
            if (patch_ff[voice_ff] == active_ff) begin
               state_in = mva_pkg::ST_ON_KEY;
            end else if (!out_full) begin
               out_push         = 1'b1;
               out_entry.ev     = mva_pkg::EV_LOAD_PATCH;
               out_entry.voice  = voice_ff;
               out_entry.patch  = active_ff;
               patch_in[voice_ff] = active_ff;
               state_in         = mva_pkg::ST_ON_KEY;
            end
         end

         mva_pkg::ST_ON_KEY: begin
            if (!out_full) begin
               out_push         = 1'b1;
               out_entry.ev     = mva_pkg::EV_KEY_ON;
               out_entry.voice  = voice_ff;
               out_entry.patch  = active_ff;
               out_entry.note   = key_ff;
               out_entry.volume = vel_ff;
               out_entry.last   = 1'b1;
               busy_in[voice_ff] = 1'b1;
               note_in[voice_ff] = key_ff;
               state_in         = mva_pkg::ST_IDLE;
            end
         end

         mva_pkg::ST_OFF_SCAN: begin
            // lowest matching voice wins
            if (busy_ff[idx_ff] && (note_ff[idx_ff] == key_ff)) begin
               if (!out_full) begin
                  out_push        = 1'b1;
                  out_entry.ev    = mva_pkg::EV_KEY_OFF;
                  out_entry.voice = idx_ff;
                  out_entry.note  = key_ff;
                  out_entry.last  = 1'b1;
                  busy_in[idx_ff] = 1'b0;
                  free_push       = 1'b1;
                  state_in        = mva_pkg::ST_IDLE;
               end
            end else if (idx_ff == mva_pkg::LAST_VOICE) begin
               state_in = mva_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         mva_pkg::ST_ALL_SCAN: begin
            if (busy_ff[idx_ff]) begin
               busy_in[idx_ff] = 1'b0;
               free_push       = 1'b1;
            end
            if (idx_ff == mva_pkg::LAST_VOICE) begin
               state_in = mva_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         default: state_in = mva_pkg::ST_IDLE;
      endcase

      // return a voice to the tail of the free list
      if (free_push && (fill_ff < mva_pkg::FILL_W'(N))) begin
         free_in[tail_ff] = free_voice;
         tail_in = (tail_ff == mva_pkg::LAST_VOICE) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mva_pkg::ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= mva_pkg::FILL_W'(N);
         active_ff <= '0;
         for (int i = 0; i < N; i++) begin
            busy_ff[i]  <= 1'b0;
            patch_ff[i] <= '0;
            free_ff[i]  <= mva_pkg::VOICE_W'(i);
         end
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
         active_ff <= active_in;
         busy_ff   <= busy_in;
         patch_ff  <= patch_in;
         free_ff   <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff  <= note_in;
      voice_ff <= voice_in;
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      vel_ff   <= vel_in;
   end

endmodule

// ===== rtl/mva_rsp_fifo.sv =====
module mva_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  mva_pkg::rsp_type  wr_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output mva_pkg::rsp_type  rd_data
);

   mva_pkg::rsp_type                  mem_ff [mva_pkg::RSPQ_DEPTH];
   logic [mva_pkg::RSPQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mva_pkg::RSPQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mva_pkg::RSPQ_CNT_W-1:0]    count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full    = (count_ff == mva_pkg::RSPQ_CNT_W'(mva_pkg::RSPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = wr_en && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/midi_voice_allocator.sv =====
// Polyphonic voice allocator for 12 voices.
// Command channel: a transaction moves on a clock edge with push high and full low.
//   A two-entry command queue decodes each command; a sequencer behind it owns the
//   voice table and the list of free voices.
// Result channel: while empty is low the oldest event sits on the rsp_ ports; it
//   moves on a clock edge with pop high. A four-entry event queue sits in front.
// CSR channel: csr_ready is always high; csr_patch_count is taken on csr_valid.
//   Write it only while no command is pending.
// Sequencer steps per command: select patch is handled when taken; note on takes the
//   free-list head, then gives an optional load-patch event, then key-on; note on with
//   no free voice is dropped when taken; note off scans one voice per cycle up to the
//   first match or the last voice; all off scans every voice. Commands are handled one
//   at a time.
// A stalled result side fills the event queue; the sequencer then waits before each
//   event and the command queue fills and raises full. Nothing is lost.
// Reset (synchronous, active high): all voices free, free list 0..11, active patch 0,
//   stored voice patches 0, patch count 1, both queues empty.
module midi_voice_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              push,
   output logic                              full,
   input  logic [mva_pkg::CMD_W-1:0]         req_cmd,
   input  logic [mva_pkg::KEY_W-1:0]         req_key,
   input  logic [mva_pkg::VEL_W-1:0]         req_velocity,
   input  logic [mva_pkg::SEL_W-1:0]         req_patch_select,
   // event channel
   output logic                              empty,
   input  logic                              pop,
   output logic [mva_pkg::EVENT_W-1:0]       rsp_event_res,
   output logic [mva_pkg::VOICE_W-1:0]       rsp_voice,
   output logic [mva_pkg::PATCH_W-1:0]       rsp_patch,
   output logic [mva_pkg::KEY_W-1:0]         rsp_note,
   output logic [mva_pkg::VEL_W-1:0]         rsp_volume,
   output logic                              rsp_last,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mva_pkg::COUNT_W-1:0]       csr_patch_count
);

   logic [mva_pkg::COUNT_W-1:0]   patch_count_ff, patch_count_in;
   logic                          cmd_empty;
   logic                          cmd_pop;
   mva_pkg::cmd_type              cmd_head;
   logic                          out_full;
   logic                          out_push;
   mva_pkg::rsp_type              out_entry;
   mva_pkg::rsp_type              rsp_head;

   // patch count register; always ready
   assign csr_ready      = 1'b1;
   assign patch_count_in = (csr_valid && csr_ready) ? csr_patch_count : patch_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         patch_count_ff <= mva_pkg::COUNT_W'(1);
      end else begin
         patch_count_ff <= patch_count_in;
      end
   end

   // front end: command queue and decode
   mva_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .cmd          (req_cmd),
      .key          (req_key),
      .velocity     (req_velocity),
      .patch_select (req_patch_select),
      .patch_count  (patch_count_ff),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .cmd_head     (cmd_head)
   );

   // back end: voice table, free list and event sequencing
   mva_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_entry (out_entry)
   );

   // event queue toward the consumer
   mva_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_entry),
      .full    (out_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_head)
   );

   assign rsp_event_res = rsp_head.ev;
   assign rsp_voice     = rsp_head.voice;
   assign rsp_patch     = rsp_head.patch;
   assign rsp_note      = rsp_head.note;
   assign rsp_volume    = rsp_head.volume;
   assign rsp_last      = rsp_head.last;

endmodule

// ===== verif/tb_midi_voice_allocator.sv =====
`timescale 1ns / 1ps

module tb_midi_voice_allocator;

   // ---------------------------------------------------------------------
   // Run knobs
   // ---------------------------------------------------------------------
   localparam int        FROM_MODEL     = -1;    // row takes its events from the voice model
   localparam int        SETTLE_CYCLES  = 64;    // > two queued full scans plus event drain
   localparam int        WATCHDOG_LIMIT = 3000;  // cycles without any transaction
   localparam int        STALL_CYCLES   = 300;   // one long hold-off on the event side
   localparam int        STALL_AT       = 60;    // ...started after this many events
   localparam int        PHASES         = 6;
   localparam int        PHASE_ITEMS    = 150;   // commands per phase
   localparam int        MAX_REPORTS    = 10;
   localparam logic [7:0] FREE_KEY      = 8'hFF;

   // one command on the request side
   typedef struct packed {
      mva_pkg::op_type            op;
      logic [mva_pkg::KEY_W-1:0]  key;
      logic [mva_pkg::VEL_W-1:0]  vel;
      logic [mva_pkg::SEL_W-1:0]  sel;
   } note_cmd_type;

   // directed script: a patch count write or a command, with events typed in
   // where they are obvious
   typedef struct {
      bit                           is_cfg;
      logic [mva_pkg::COUNT_W-1:0]  cfg_val;
      note_cmd_type                 cmd;
      int                           n_typed;
      mva_pkg::rsp_type             typed;
   } script_row_type;

   // ---------------------------------------------------------------------
   // DUT
   // ---------------------------------------------------------------------
   logic                         clock;
   logic                         reset;
   logic                         push;
   logic                         full;
   logic [mva_pkg::CMD_W-1:0]    req_cmd;
   logic [mva_pkg::KEY_W-1:0]    req_key;
   logic [mva_pkg::VEL_W-1:0]    req_velocity;
   logic [mva_pkg::SEL_W-1:0]    req_patch_select;
   logic                         empty;
   logic                         pop;
   logic [mva_pkg::EVENT_W-1:0]  rsp_event_res;
   logic [mva_pkg::VOICE_W-1:0]  rsp_voice;
   logic [mva_pkg::PATCH_W-1:0]  rsp_patch;
   logic [mva_pkg::KEY_W-1:0]    rsp_note;
   logic [mva_pkg::VEL_W-1:0]    rsp_volume;
   logic                         rsp_last;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [mva_pkg::COUNT_W-1:0]  csr_patch_count;

   midi_voice_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_velocity     (req_velocity),
      .req_patch_select (req_patch_select),
      .empty            (empty),
      .pop              (pop),
      .rsp_event_res    (rsp_event_res),
      .rsp_voice        (rsp_voice),
      .rsp_patch        (rsp_patch),
      .rsp_note         (rsp_note),
      .rsp_volume       (rsp_volume),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_patch_count  (csr_patch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Voice model: table, free ring, active patch, patch count
   // ---------------------------------------------------------------------
   logic [7:0]                   voice_key  [mva_pkg::NVOICES];
   logic [mva_pkg::PATCH_W-1:0]  voice_prog [mva_pkg::NVOICES];
   int                           free_ring  [mva_pkg::NVOICES];
   int                           ring_head;
   int                           ring_fill;
   logic [mva_pkg::PATCH_W-1:0]  cur_patch;
   logic [mva_pkg::COUNT_W-1:0]  cfg_count;

   mva_pkg::rsp_type    step_events[$];   // events raised by the last command
   mva_pkg::rsp_type    due_events[$];    // events owed by the DUT, oldest first

   int                  mismatches   = 0;
   int                  events_seen  = 0;
   int                  quiet_cycles = 0;
   int                  send_calm    = 0;
   int                  recv_calm    = 0;

   function automatic mva_pkg::rsp_type event_of(mva_pkg::event_type e, int voice,
                                                 int patch, int note, int vol, bit last);
      mva_pkg::rsp_type r;
      r.ev     = e;
      r.voice  = voice[mva_pkg::VOICE_W-1:0];
      r.patch  = patch[mva_pkg::PATCH_W-1:0];
      r.note   = note[mva_pkg::KEY_W-1:0];
      r.volume = vol[mva_pkg::VEL_W-1:0];
      r.last   = last;
      return r;
   endfunction

   function automatic void ring_push(int v);
      if (ring_fill < mva_pkg::NVOICES) begin
         free_ring[(ring_head + ring_fill) % mva_pkg::NVOICES] = v;
         ring_fill++;
      end
   endfunction

   // Advance the voice model by one accepted command; events land in step_events.
   function automatic void apply_command(note_cmd_type c);
      int  v;
      bit  found;
      step_events.delete();
      case (c.op)
         mva_pkg::OP_NOTE_ON: begin
            // no free voice: note dropped
            if (ring_fill != 0) begin
               v = free_ring[ring_head] % mva_pkg::NVOICES;
               ring_head = (ring_head + 1) % mva_pkg::NVOICES;
               ring_fill--;
               if (voice_prog[v] != cur_patch) begin
                  voice_prog[v] = cur_patch;
                  step_events.push_back(event_of(mva_pkg::EV_LOAD_PATCH, v, cur_patch,
                                                 0, 0, 1'b0));
               end
               voice_key[v] = {1'b0, c.key};
               step_events.push_back(event_of(mva_pkg::EV_KEY_ON, v, cur_patch, c.key,
                                              c.vel, 1'b1));
            end
         end
         mva_pkg::OP_NOTE_OFF: begin
            // lowest voice holding the key wins
            found = 1'b0;
            for (int i = 0; i < mva_pkg::NVOICES; i++) begin
               if (!found && voice_key[i] == {1'b0, c.key}) begin
                  found = 1'b1;
                  voice_key[i] = FREE_KEY;
                  ring_push(i);
                  step_events.push_back(event_of(mva_pkg::EV_KEY_OFF, i, 0, c.key, 0,
                                                 1'b1));
               end
            end
         end
         mva_pkg::OP_SELECT: begin
            if (c.sel < cfg_count && c.sel < mva_pkg::MAX_PATCHES)
               cur_patch = c.sel[mva_pkg::PATCH_W-1:0];
         end
         default: begin
            // silent release, ascending voice order
            for (int i = 0; i < mva_pkg::NVOICES; i++) begin
               if (voice_key[i] != FREE_KEY) begin
                  voice_key[i] = FREE_KEY;
                  ring_push(i);
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic script_row_type cmd_row(mva_pkg::op_type op, int key, int vel,
                                              int sel, int n_typed,
                                              mva_pkg::rsp_type typed);
      script_row_type r;
      r.is_cfg  = 1'b0;
      r.cfg_val = '0;
      r.cmd.op  = op;
      r.cmd.key = key[mva_pkg::KEY_W-1:0];
      r.cmd.vel = vel[mva_pkg::VEL_W-1:0];
      r.cmd.sel = sel[mva_pkg::SEL_W-1:0];
      r.n_typed = n_typed;
      r.typed   = typed;
      return r;
   endfunction

   function automatic script_row_type cfg_row(int v);
      script_row_type r;
      r.is_cfg  = 1'b1;
      r.cfg_val = v[mva_pkg::COUNT_W-1:0];
      r.cmd     = '0;
      r.n_typed = 0;
      r.typed   = '0;
      return r;
   endfunction

   // Idle cycles before the next transaction on one side: mostly a uniform random draw, with
   // runs of back-to-back traffic mixed in.
   function automatic int pace(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Mostly playable traffic: note-ons, note-offs of held keys, valid selects.
   // The rest is noise: stray note-offs, out-of-range selects, all-offs.
   function automatic note_cmd_type draw_command();
      note_cmd_type c;
      int           busy[$];
      int           r;
      c.op  = mva_pkg::OP_NOTE_ON;
      c.key = mva_pkg::KEY_W'($urandom_range(0, 127));
      c.vel = mva_pkg::VEL_W'($urandom_range(0, 127));
      c.sel = mva_pkg::SEL_W'($urandom_range(0, 127));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         // a narrow key band now and then so several voices share a key
         if ($urandom_range(0, 3) == 0)
            c.key = mva_pkg::KEY_W'($urandom_range(60, 63));
      end else if (r < 82) begin
         c.op = mva_pkg::OP_NOTE_OFF;
         for (int i = 0; i < mva_pkg::NVOICES; i++)
            if (voice_key[i] != FREE_KEY)
               busy.push_back(i);
         if (busy.size() != 0 && $urandom_range(0, 9) != 0)
            c.key = voice_key[busy[$urandom_range(0, busy.size() - 1)]][mva_pkg::KEY_W-1:0];
      end else if (r < 96) begin
         c.op = mva_pkg::OP_SELECT;
         if (cfg_count != 0 && $urandom_range(0, 3) != 0)
            c.sel = mva_pkg::SEL_W'($urandom_range(0, cfg_count - 1));
      end else begin
         c.op = mva_pkg::OP_ALL_OFF;
      end
      return c;
   endfunction

   // One command transaction; the model runs on acceptance.
   task automatic send_command(note_cmd_type c, int n_typed, mva_pkg::rsp_type typed);
      int gap;
      gap = pace(send_calm);
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push             <= 1'b1;
      req_cmd          <= c.op;
      req_key          <= c.key;
      req_velocity     <= c.vel;
      req_patch_select <= c.sel;
      @(posedge clock);
      while (full)
         @(posedge clock);
      apply_command(c);
      if (n_typed == FROM_MODEL) begin
         foreach (step_events[i])
            due_events.push_back(step_events[i]);
      end else if (n_typed == 1) begin
         due_events.push_back(typed);
      end
   endtask

   // Patch count write, only with the block drained and quiet.
   task automatic write_patch_count(logic [mva_pkg::COUNT_W-1:0] v);
      @(negedge clock);
      push <= 1'b0;
      while (due_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_patch_count <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cfg_count = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: event %0d %s mismatch: expected %0d, got %0d",
                  $realtime, events_seen, what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Event side: random pop pacing, one long hold-off, field checks
   // ---------------------------------------------------------------------
   initial begin
      mva_pkg::rsp_type got;
      mva_pkg::rsp_type want;
      int               gap;
      bit               stalled;
      pop     = 1'b0;
      stalled = 1'b0;
      wait (!reset);
      forever begin
         gap = pace(recv_calm);
         // long hold-off while commands keep coming: queues fill and full rises
         if (!stalled && events_seen >= STALL_AT) begin
            stalled = 1'b1;
            gap     = STALL_CYCLES;
         end
         repeat (gap) begin
            @(negedge clock);
            pop <= 1'b0;
         end
         @(negedge clock);
         pop <= 1'b1;
         @(posedge clock);
         while (empty)
            @(posedge clock);
         got.ev     = mva_pkg::event_type'(rsp_event_res);
         got.voice  = rsp_voice;
         got.patch  = rsp_patch;
         got.note   = rsp_note;
         got.volume = rsp_volume;
         got.last   = rsp_last;
         if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: unexpected event: ev %0d voice %0d patch %0d",
                         " note %0d vol %0d last %0d"},
                        $realtime, got.ev, got.voice, got.patch, got.note, got.volume,
                        got.last);
         end else begin
            want = due_events.pop_front();
            if (got.ev !== want.ev)
               note_mismatch("event_res", 8'(want.ev), 8'(got.ev));
            if (got.voice !== want.voice)
               note_mismatch("voice", 8'(want.voice), 8'(got.voice));
            if (got.patch !== want.patch)
               note_mismatch("patch", 8'(want.patch), 8'(got.patch));
            if (got.note !== want.note)
               note_mismatch("note", 8'(want.note), 8'(got.note));
            if (got.volume !== want.volume)
               note_mismatch("volume", 8'(want.volume), 8'(got.volume));
            if (got.last !== want.last)
               note_mismatch("last", 8'(want.last), 8'(got.last));
         end
         events_seen++;
      end
   end

   // Watchdog: any run of idle cycles this long means a hang
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      script_row_type               script[$];
      note_cmd_type                 c;
      logic [mva_pkg::COUNT_W-1:0]  phase_counts[PHASES];

      reset            = 1'b1;
      push             = 1'b0;
      req_cmd          = mva_pkg::OP_NOTE_ON;
      req_key          = '0;
      req_velocity     = '0;
      req_patch_select = '0;
      csr_valid        = 1'b0;
      csr_patch_count  = '0;

      // model state after reset
      for (int i = 0; i < mva_pkg::NVOICES; i++) begin
         voice_key[i]  = FREE_KEY;
         voice_prog[i] = '0;
         free_ring[i]  = i;
      end
      ring_head = 0;
      ring_fill = mva_pkg::NVOICES;
      cur_patch = '0;
      cfg_count = mva_pkg::COUNT_W'(1);

      // --- directed script -------------------------------------------------
      // after reset: patch count 1, active patch 0, voices handed out 0, 1, 2...
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 0, 0, 0, 1,
                               event_of(mva_pkg::EV_KEY_ON, 0, 0, 0, 0, 1'b1)));
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 127, 127, 127, 1,
                               event_of(mva_pkg::EV_KEY_ON, 1, 0, 127, 127, 1'b1)));
      // same key on a second voice
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 127, 1, 0, 1,
                               event_of(mva_pkg::EV_KEY_ON, 2, 0, 127, 1, 1'b1)));
      // shared key: lowest voice goes first
      script.push_back(cmd_row(mva_pkg::OP_NOTE_OFF, 127, 0, 0, 1,
                               event_of(mva_pkg::EV_KEY_OFF, 1, 0, 127, 0, 1'b1)));
      script.push_back(cmd_row(mva_pkg::OP_NOTE_OFF, 127, 127, 127, 1,
                               event_of(mva_pkg::EV_KEY_OFF, 2, 0, 127, 0, 1'b1)));
      // key no longer held: nothing
      script.push_back(cmd_row(mva_pkg::OP_NOTE_OFF, 127, 0, 0, 0, '0));
      // patch 1 with a count of 1 is out of range
      script.push_back(cmd_row(mva_pkg::OP_SELECT, 0, 0, 1, 0, '0));
      script.push_back(cfg_row(mva_pkg::MAX_PATCHES));
      script.push_back(cmd_row(mva_pkg::OP_SELECT, 0, 0, 63, 0, '0));
      // voice 3 still holds patch 0: load, then key-on
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 60, 100, 0, FROM_MODEL, '0));
      script.push_back(cmd_row(mva_pkg::OP_SELECT, 0, 0, 64, 0, '0));
      // count above the patch limit; select 127 is not below the count, so refused
      script.push_back(cfg_row(127));
      script.push_back(cmd_row(mva_pkg::OP_SELECT, 0, 0, 127, 0, '0));
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 61, 64, 0, FROM_MODEL, '0));
      script.push_back(cmd_row(mva_pkg::OP_NOTE_OFF, 0, 0, 0, 1,
                               event_of(mva_pkg::EV_KEY_OFF, 0, 0, 0, 0, 1'b1)));
      // count of zero: every select refused
      script.push_back(cfg_row(0));
      script.push_back(cmd_row(mva_pkg::OP_SELECT, 0, 0, 0, 0, '0));
      // use up the ten free voices, then one note with none left
      for (int i = 0; i < 10; i++)
         script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 20 + i * 11, 127 - i * 13, i,
                                  FROM_MODEL, '0));
      script.push_back(cmd_row(mva_pkg::OP_NOTE_ON, 90, 90, 0, 0, '0));
      // all busy voices released without events
      script.push_back(cmd_row(mva_pkg::OP_ALL_OFF, 0, 0, 0, 0, '0));

      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg)
            write_patch_count(script[i].cfg_val);
         else
            send_command(script[i].cmd, script[i].n_typed, script[i].typed);
      end

      // --- random phases, one patch count each ------------------------------
      phase_counts[0] = mva_pkg::COUNT_W'(mva_pkg::MAX_PATCHES);
      phase_counts[1] = mva_pkg::COUNT_W'(1);
      phase_counts[2] = mva_pkg::COUNT_W'(127);
      phase_counts[3] = mva_pkg::COUNT_W'($urandom_range(2, mva_pkg::MAX_PATCHES - 1));
      phase_counts[4] = mva_pkg::COUNT_W'($urandom_range(1, mva_pkg::MAX_PATCHES));
      phase_counts[5] = '0;
      for (int p = 0; p < PHASES; p++) begin
         write_patch_count(phase_counts[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            c = draw_command();
            send_command(c, FROM_MODEL, '0);
         end
      end

      // --- drain and verdict --------------------------------------------------
      @(negedge clock);
      push <= 1'b0;
      while (due_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
